/* hdl/prf_pkg.sv */
// ----------------------------------------------------------------------------
// prf_pkg: shared constants for the Pollard rho factor core
// Widths, status codes and saturation limits.
// ----------------------------------------------------------------------------
`default_nettype none
package prf_pkg;
    localparam int NUM_WIDTH = 32;
    localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);
    localparam logic [1:0] STATUS_PROPER  = 2'd0;
    localparam logic [1:0] STATUS_TRIVIAL = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;
    localparam logic [31:0] STEP_MAX = 32'hFFFF_FFFF;
    localparam logic [32:0] ROUND_MAX = 33'h1_FFFF_FFFF;

    typedef logic [NUM_WIDTH-1:0] num_t;
    typedef logic [CNT_WIDTH-1:0] cnt_t;
endpackage
`default_nettype wire

/* hdl/prf_modunit.sv */
// ----------------------------------------------------------------------------
// prf_modunit: bit-serial modular unit
// Computes (a*b + 1) mod m, or b mod m (with a = 1 and no +1), one bit per cycle.
// Operand a must be below m, or equal to it; b may take any value.
// ----------------------------------------------------------------------------
`default_nettype none
module prf_modunit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 go,
    input  wire prf_pkg::num_t  a,
    input  wire prf_pkg::num_t  b,
    input  wire prf_pkg::num_t  m,
    input  wire                 add_one,
    output logic                done,
    output prf_pkg::num_t       result
);
    import prf_pkg::*;

    // Horner over multiplier bits, MSB first: acc = 2*acc + bit*a (mod m)
    logic               busy_reg, busy_next;
    cnt_t               cnt_reg, cnt_next;
    logic [NUM_WIDTH:0] acc_reg, acc_next;
    num_t               a_reg, b_reg, m_reg;
    logic               one_reg;
    logic               done_reg, done_next;

    logic [NUM_WIDTH+1:0] dbl;
    logic [NUM_WIDTH+1:0] s1;
    logic [NUM_WIDTH+1:0] s2;
    logic [NUM_WIDTH+1:0] mx;

    always_comb
    begin
        mx  = {2'b00, m_reg};
        dbl = {acc_reg, 1'b0};
        s1  = (dbl >= mx) ? dbl - mx : dbl;
        s2  = s1 + (b_reg[NUM_WIDTH-1] ? {2'b00, a_reg} : '0);
        if (s2 >= mx)
        begin
            s2 = s2 - mx;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        if (go && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = cnt_t'(NUM_WIDTH);
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                // final +1 step
                busy_next = 1'b0;
                done_next = 1'b1;
                if (one_reg)
                begin
                    acc_next = acc_reg + 1'b1;
                    if (acc_next >= {1'b0, m_reg})
                    begin
                        acc_next = acc_next - {1'b0, m_reg};
                    end
                end
            end
            else
            begin
                acc_next = s2[NUM_WIDTH:0];
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // hold operands; shift multiplier left one bit a cycle
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (go && !busy_reg)
        begin
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
            one_reg <= add_one;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            b_reg <= {b_reg[NUM_WIDTH-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = acc_reg[NUM_WIDTH-1:0];

    property p_done_one;
        @(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg;
    endproperty
    a_done_one: assert property (p_done_one) else $error("done while busy");
    a_res_lt_m: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (acc_reg < {1'b0, m_reg})) else $error("result not reduced");
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !busy_reg) |=> busy_reg) else $error("start lost");
endmodule
`default_nettype wire

/* hdl/pollard_rho_factor_core.sv */
// ----------------------------------------------------------------------------
// pollard_rho_factor_core: Pollard rho factor search, Brent cycle detection
// Walks x <- x*x+1 mod n and runs Euclid at every step on a shared
// bit-serial modular unit.
// ----------------------------------------------------------------------------
//  channel | ports                   | transfer
//  input   | start, number           | start && !busy
//  result  | done, factor/status/steps| done high for one cycle
//
//  Each walk step costs one square plus one modular reduction per Euclid
//  iteration and a final gcd test; the total per item is data dependent,
//  roughly sqrt(smallest factor) steps.
//  Inputs below two skip the walk and go straight to the output state. Reset clears control only.
//  The receiver cannot stall: the result is presented once.
// ----------------------------------------------------------------------------
`default_nettype none
module pollard_rho_factor_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire prf_pkg::num_t  number,
    output logic                busy,
    output logic                done,
    output prf_pkg::num_t       factor,
    output logic [1:0]          status,
    output logic [31:0]         steps
);
    import prf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_GCD  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg;
    num_t        n_reg, x_reg, y_reg, gl_reg, gr_reg;
    logic [32:0] rlen_reg, rstep_reg;
    logic [31:0] tot_reg;
    logic        done_reg;
    logic        go_reg;
    logic        sq_mode_reg;
    num_t        fac_reg;
    logic [1:0]  st_reg;

    logic        mu_done;
    num_t        mu_res;
    num_t        mu_a, mu_b;
    num_t        diff;

    // square x, or reduce gcd_left by gcd_right with the multiplier bits
    assign mu_a = sq_mode_reg ? x_reg : num_t'(1);
    assign mu_b = sq_mode_reg ? x_reg : gl_reg;

    prf_modunit u_mod (
        .clk(clk), .rst_n(rst_n), .go(go_reg), .a(mu_a), .b(mu_b),
        .m(sq_mode_reg ? n_reg : gr_reg), .add_one(sq_mode_reg),
        .done(mu_done), .result(mu_res)
    );

    assign diff = (mu_res >= y_reg) ? mu_res - y_reg : y_reg - mu_res;

    // sequence the walk and the Euclid loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            go_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            go_reg   <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (number < num_t'(2))
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            go_reg    <= 1'b1;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    if (mu_done)
                    begin
                        state_reg <= ST_GCD;
                    end
                end
                ST_GCD:
                begin
                    if (gr_reg == '0)
                    begin
                        if (gl_reg != num_t'(1))
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            go_reg    <= 1'b1;
                            state_reg <= ST_SQ;
                        end
                    end
                    else
                    begin
                        go_reg    <= 1'b1;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (mu_done)
                    begin
                        state_reg <= ST_GCD;
                    end
                end
                ST_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sq_mode_reg <= 1'b1;
                    fac_reg     <= number;
                    st_reg      <= STATUS_INVALID;
                    tot_reg     <= '0;
                    if (number >= num_t'(2))
                    begin
                        n_reg     <= number;
                        x_reg     <= num_t'(2);
                        y_reg     <= num_t'(2);
                        rlen_reg  <= 33'd2;
                        rstep_reg <= '0;
                    end
                end
            end
            ST_SQ:
            begin
                if (mu_done)
                begin
                    x_reg  <= mu_res;
                    gl_reg <= diff;
                    gr_reg <= n_reg;
                    if (tot_reg != STEP_MAX)
                    begin
                        tot_reg <= tot_reg + 1'b1;
                    end
                    if (rstep_reg + 1'b1 >= rlen_reg)
                    begin
                        rstep_reg <= '0;
                        rlen_reg  <= (rlen_reg > (ROUND_MAX >> 1)) ? ROUND_MAX
                                                                  : {rlen_reg[31:0], 1'b0};
                        y_reg     <= mu_res;
                    end
                    else
                    begin
                        rstep_reg <= rstep_reg + 1'b1;
                    end
                    sq_mode_reg <= 1'b0;
                end
            end
            ST_GCD:
            begin
                if (gr_reg == '0)
                begin
                    fac_reg     <= gl_reg;
                    st_reg      <= (gl_reg == n_reg) ? STATUS_TRIVIAL : STATUS_PROPER;
                    sq_mode_reg <= 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (mu_done)
                begin
                    gl_reg <= gr_reg;
                    gr_reg <= mu_res;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign factor = fac_reg;
    assign status = st_reg;
    assign steps  = tot_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == ST_IDLE) else $error("done outside idle");
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |=> done_reg) else $error("result dropped");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> st_reg != 2'd3) else $error("bad status");
endmodule
`default_nettype wire
